[rtl/blnf_pkg.sv]
`timescale 1ns / 1ps

package blnf_pkg;

	localparam int MAX_LABELS = 64;
	localparam int COUNT_BITS = 8;
	localparam int LBL_W      = 6;
	localparam int MINC_W     = 8;
	localparam int IDX_W      = $clog2(MAX_LABELS);
	localparam int SEEN_W     = $clog2(MAX_LABELS + 1);
	localparam int CMP_W      = (COUNT_BITS > MINC_W) ? COUNT_BITS : MINC_W;

	localparam logic [COUNT_BITS-1:0] TALLY_MAX = {COUNT_BITS{1'b1}};

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LABEL_LIMIT = 1'b1;

	localparam logic [MINC_W-1:0] MIN_COUNT_RST   = 8'd3;
	localparam logic [LBL_W-1:0]  LABEL_LIMIT_RST = 6'd63;

	typedef struct packed {
		logic [LBL_W-1:0] pixel_label;
		logic             on_border;
		logic             last_pixel;
	} pix_t;

	typedef struct packed {
		logic [LBL_W-1:0] nbr_label;
		logic             found;
		logic             last;
	} res_t;

	typedef struct packed {
		logic pix_load;
		logic ord_rd;
		logic tal_rd;
		logic advance;
		logic take;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic qualifies;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/blnf_ctrl.sv]
`timescale 1ns / 1ps

module blnf_ctrl import blnf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pix_valid,
	input  logic     last_pixel,
	output logic     pix_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_WAIT = 3'd1;
	localparam logic [2:0] ST_ORD  = 3'd2;
	localparam logic [2:0] ST_TAL  = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		pix_stall = 1'b1;
		state_nxt = state_q;
		unique case (state_q)
			ST_RUN: begin
				pix_stall    = 1'b0;
				cmd.pix_load = pix_valid;
				if (pix_valid && last_pixel) begin
					state_nxt = ST_WAIT;
				end
			end
			// The final pixel finishes its tally update here.
			ST_WAIT: begin
				state_nxt = ST_ORD;
			end
			ST_ORD: begin
				if (stat.walk_done) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.ord_rd = 1'b1;
					state_nxt  = ST_TAL;
				end
			end
			ST_TAL: begin
				cmd.tal_rd = 1'b1;
				state_nxt  = ST_CHK;
			end
			ST_CHK: begin
				if (!stat.qualifies) begin
					cmd.advance = 1'b1;
					state_nxt   = ST_ORD;
				end else if (!stat.pend_valid || stat.out_free) begin
					cmd.advance = 1'b1;
					cmd.take    = 1'b1;
					state_nxt   = ST_ORD;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_RUN;
				end
			end
			default: begin
				state_nxt = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/blnf_datapath.sv]
`timescale 1ns / 1ps

module blnf_datapath import blnf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  pix_t              pix,
	input  logic [MINC_W-1:0] min_count,
	input  logic [LBL_W-1:0]  label_limit,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res
);

	logic [COUNT_BITS-1:0] tally_mem [MAX_LABELS];
	logic [LBL_W-1:0]      order_mem [MAX_LABELS];
	logic [MAX_LABELS-1:0] tally_vld_q;

	logic [COUNT_BITS-1:0] tally_rd_q;
	logic                  tally_rd_vld_q;
	logic [LBL_W-1:0]      order_rd_q;

	logic                  cnt_v_s1;
	logic                  fwd_s1;
	logic [LBL_W-1:0]      lab_s1;
	logic [COUNT_BITS-1:0] last_new_q;

	logic [SEEN_W-1:0]     seen_total_q;
	logic [SEEN_W-1:0]     walk_idx_q;
	logic                  pend_valid_q;
	logic [LBL_W-1:0]      pend_label_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic                  pix_counts;
	logic [LBL_W-1:0]      rd_label;
	logic [IDX_W-1:0]      rd_idx;
	logic                  tally_rd_en;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  first_time;
	logic [COUNT_BITS-1:0] chk_cnt;
	logic                  out_free;

	always_comb begin
		pix_counts = pix.on_border && (pix.pixel_label <= label_limit)
			&& (int'(pix.pixel_label) < MAX_LABELS);
		rd_label    = cmd.tal_rd ? order_rd_q : pix.pixel_label;
		rd_idx      = IDX_W'(rd_label);
		tally_rd_en = cmd.pix_load || cmd.tal_rd;

		// A label repeated on the very next pixel takes the count still being written.
		old_cnt    = fwd_s1 ? last_new_q : (tally_rd_vld_q ? tally_rd_q : '0);
		new_cnt    = (old_cnt == TALLY_MAX) ? old_cnt : old_cnt + COUNT_BITS'(1);
		first_time = (old_cnt == '0) && (seen_total_q < SEEN_W'(MAX_LABELS));

		chk_cnt  = tally_rd_vld_q ? tally_rd_q : '0;
		out_free = !res_valid_q || !res_stall;

		stat.walk_done  = (walk_idx_q == seen_total_q);
		stat.qualifies  = (order_rd_q != '0) && (int'(order_rd_q) < MAX_LABELS)
			&& (CMP_W'(chk_cnt) >= CMP_W'(min_count));
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (tally_rd_en) begin
			tally_rd_q <= tally_mem[rd_idx];
		end
		if (cnt_v_s1) begin
			tally_mem[IDX_W'(lab_s1)] <= new_cnt;
			last_new_q                <= new_cnt;
		end
		if (cmd.ord_rd) begin
			order_rd_q <= order_mem[walk_idx_q[IDX_W-1:0]];
		end
		if (cnt_v_s1 && first_time) begin
			order_mem[seen_total_q[IDX_W-1:0]] <= lab_s1;
		end
		if (cmd.pix_load) begin
			lab_s1 <= pix.pixel_label;
		end
		if (cmd.take) begin
			pend_label_q <= order_rd_q;
		end
		if (cmd.finish) begin
			res_q.nbr_label <= pend_valid_q ? pend_label_q : '0;
			res_q.found     <= pend_valid_q;
			res_q.last      <= 1'b1;
		end else if (cmd.take && pend_valid_q) begin
			res_q.nbr_label <= pend_label_q;
			res_q.found     <= 1'b1;
			res_q.last      <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_rd_vld_q <= 1'b0;
			cnt_v_s1       <= 1'b0;
			fwd_s1         <= 1'b0;
			tally_vld_q    <= '0;
			seen_total_q   <= '0;
			walk_idx_q     <= '0;
			pend_valid_q   <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (tally_rd_en) begin
				tally_rd_vld_q <= tally_vld_q[rd_idx];
			end
			cnt_v_s1 <= cmd.pix_load && pix_counts;
			fwd_s1   <= cmd.pix_load && cnt_v_s1 && (lab_s1 == pix.pixel_label);

			if (cmd.finish) begin
				tally_vld_q  <= '0;
				seen_total_q <= '0;
			end else if (cnt_v_s1) begin
				tally_vld_q[IDX_W'(lab_s1)] <= 1'b1;
				if (first_time) begin
					seen_total_q <= seen_total_q + SEEN_W'(1);
				end
			end

			if (cmd.finish) begin
				walk_idx_q <= '0;
			end else if (cmd.advance) begin
				walk_idx_q <= walk_idx_q + SEEN_W'(1);
			end

			if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.take) begin
				pend_valid_q <= 1'b1;
			end

			if (cmd.finish || (cmd.take && pend_valid_q)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/border_label_neighbor_finder.sv]
// Pixels are taken one per cycle while a frame streams in; each tally update
// completes in the cycle after its pixel is accepted.
// After the last pixel the input stalls while the first-seen list of distinct labels is walked:
// each entry of that list costs two memory reads and a check.
// Output stalls lengthen that walk. Reset clears all control state and the tally valid bits
// at once, so no clearing pass is needed; registers return to min_count 3, label limit 63.
`timescale 1ns / 1ps

module border_label_neighbor_finder import blnf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pix_t                 pix,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [MINC_W-1:0] min_count_q;
	logic [LBL_W-1:0]  label_limit_q;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q   <= MIN_COUNT_RST;
			label_limit_q <= LABEL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_COUNT:   min_count_q   <= cfg_data[MINC_W-1:0];
				REG_LABEL_LIMIT: label_limit_q <= cfg_data[LBL_W-1:0];
				default: ;
			endcase
		end
	end

	blnf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.last_pixel (pix.last_pixel),
		.pix_stall  (pix_stall),
		.cmd        (cmd),
		.stat       (stat)
	);

	blnf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.pix         (pix),
		.min_count   (min_count_q),
		.label_limit (label_limit_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

`ifndef NO_ASSERTIONS
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && pix.last_pixel |=> pix_stall)
		else $error("input taken right after the last pixel of a frame");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.last)
		else $error("empty-frame item without last mark");

	a_empty_label_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.nbr_label == '0)
		else $error("empty-frame item carries a nonzero label");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import blnf_pkg::*;

	localparam int WALK_CYCLES = 3 * MAX_LABELS + 16;
	localparam int STALL_LIMIT = 5000;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 pix_valid = 1'b0;
	logic                 pix_stall;
	pix_t                 pix       = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	border_label_neighbor_finder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block's stores and registers.
	logic [COUNT_BITS-1:0] tally_counts [MAX_LABELS];
	logic [LBL_W-1:0]      first_order  [MAX_LABELS];
	int unsigned           distinct_seen   = 0;
	logic [MINC_W-1:0]     cfg_min_count   = MIN_COUNT_RST;
	logic [LBL_W-1:0]      cfg_label_limit = LABEL_LIMIT_RST;

	pix_t pending_pixels [$];
	res_t expected_neighbors [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fail_count    = 0;
	int unsigned idle_cycles   = 0;
	res_t        want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_tallies();
		int i;
		for (i = 0; i < MAX_LABELS; i++) begin
			tally_counts[i] = '0;
			first_order[i]  = '0;
		end
		distinct_seen = 0;
	endtask

	// Counts one accepted pixel and, on the frame's last pixel, queues the neighbor list.
	task automatic tally_pixel(input pix_t p);
		int   k;
		int   n_hits;
		int   n;
		res_t r;
		if (p.on_border && p.pixel_label <= cfg_label_limit) begin
			if (tally_counts[p.pixel_label] == '0 && distinct_seen < MAX_LABELS) begin
				first_order[distinct_seen] = p.pixel_label;
				distinct_seen++;
			end
			if (tally_counts[p.pixel_label] != TALLY_MAX)
				tally_counts[p.pixel_label] = tally_counts[p.pixel_label] + 1'b1;
		end
		if (p.last_pixel) begin
			n_hits = 0;
			for (k = 0; k < distinct_seen; k++)
				if (first_order[k] != '0 && tally_counts[first_order[k]] >= cfg_min_count)
					n_hits++;
			if (n_hits == 0) begin
				r.nbr_label = '0;
				r.found     = 1'b0;
				r.last      = 1'b1;
				expected_neighbors = {expected_neighbors, r};
			end else begin
				n = 0;
				for (k = 0; k < distinct_seen; k++) begin
					if (first_order[k] != '0 && tally_counts[first_order[k]] >= cfg_min_count) begin
						n++;
						r.nbr_label = first_order[k];
						r.found     = 1'b1;
						r.last      = (n == n_hits);
						expected_neighbors = {expected_neighbors, r};
					end
				end
			end
			clear_tallies();
		end
	endtask

	// Pixel driver: holds an item while stalled, otherwise may idle at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (!pix_valid || !pix_stall) begin
			if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				pix       <= pending_pixels.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Monitor: follows register writes and accepted pixels, then checks results.
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_COUNT:   cfg_min_count   = cfg_data[MINC_W-1:0];
					REG_LABEL_LIMIT: cfg_label_limit = cfg_data[LBL_W-1:0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall)
				tally_pixel(pix);
			if (res_valid && !res_stall) begin
				if (expected_neighbors.size() == 0) begin
					$error("unexpected result: nbr_label %0d found %0b last %0b",
						res.nbr_label, res.found, res.last);
					fail_count++;
				end else begin
					want = expected_neighbors.pop_front();
					if (res.nbr_label !== want.nbr_label) begin
						$error("nbr_label: expected %0d, actual %0d",
							want.nbr_label, res.nbr_label);
						fail_count++;
					end
					if (res.found !== want.found) begin
						$error("found: expected %0b, actual %0b", want.found, res.found);
						fail_count++;
					end
					if (res.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, res.last);
						fail_count++;
					end
				end
			end
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Waits until every pixel is taken and every result has come, then lets the walk settle.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || pix_valid || expected_neighbors.size() != 0);
		repeat (WALK_CYCLES) @(posedge clk);
	endtask

	task automatic add_pixel(input logic [LBL_W-1:0] label, input logic border,
			input logic ends);
		pix_t p;
		p.pixel_label = label;
		p.on_border   = border;
		p.last_pixel  = ends;
		pending_pixels = {pending_pixels, p};
	endtask

	task automatic add_run(input logic [LBL_W-1:0] label, input int count);
		int i;
		for (i = 0; i < count; i++)
			add_pixel(label, 1'b1, 1'b0);
	endtask

	// Every label once, in shuffled order, so that the full neighbor list comes out.
	task automatic add_all_labels_frame();
		logic [LBL_W-1:0] order_buf [MAX_LABELS];
		logic [LBL_W-1:0] tmp;
		int               i;
		int               j;
		for (i = 0; i < MAX_LABELS; i++)
			order_buf[i] = LBL_W'(i);
		for (i = MAX_LABELS - 1; i > 0; i--) begin
			j            = $urandom_range(i);
			tmp          = order_buf[i];
			order_buf[i] = order_buf[j];
			order_buf[j] = tmp;
		end
		for (i = 0; i < MAX_LABELS; i++)
			add_pixel(order_buf[i], 1'b1, i == MAX_LABELS - 1);
	endtask

	// Mostly frames drawn from a small pool of labels so that counts build up;
	// some single-pixel frames, frames off the border, and stray labels as noise.
	task automatic add_random_frames(input int n_items);
		int added;
		int len;
		int pool;
		int base;
		int border_pct;
		int i;
		logic [LBL_W-1:0] label;
		added = 0;
		while (added < n_items) begin
			case ($urandom_range(9))
				0:       len = 1;
				1:       len = $urandom_range(40, 60);
				default: len = $urandom_range(2, 24);
			endcase
			pool       = $urandom_range(1, 8);
			base       = $urandom_range(63);
			border_pct = ($urandom_range(9) == 0) ? 0 : $urandom_range(50, 95);
			for (i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0)
					label = LBL_W'($urandom_range(63));
				else
					label = LBL_W'((base + $urandom_range(pool - 1)) % MAX_LABELS);
				add_pixel(label, $urandom_range(99) < border_pct, i == len - 1);
			end
			added += len;
		end
	endtask

	initial begin
		clear_tallies();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings; sender idles lightly, receiver stalls heavily.
		send_idle_pct = 12;
		recv_idle_pct = 76;
		// A frame with nothing on the border reports an empty list.
		add_pixel(6'd5, 1'b0, 1'b1);
		// Label zero is counted but never reported; one label stays below the threshold
		// until the last pixel, which counts before the list is emitted.
		add_run(6'd0, 3);
		add_run(6'd63, 3);
		add_run(6'd5, 2);
		add_pixel(6'd7, 1'b0, 1'b0);
		add_pixel(6'd5, 1'b1, 1'b1);
		add_run(6'd12, 2);
		add_pixel(6'd12, 1'b1, 1'b1);
		// The previous frame's counts must not carry over.
		add_pixel(6'd12, 1'b1, 1'b0);
		add_pixel(6'd12, 1'b0, 1'b1);
		drain();

		write_reg(REG_MIN_COUNT, 8'd1);
		write_reg(REG_LABEL_LIMIT, 8'd63);
		add_all_labels_frame();
		add_random_frames(40);
		drain();

		// Receiver now idles lightly and sender heavily.
		send_idle_pct = 76;
		recv_idle_pct = 12;
		// Highest threshold: a short run never reaches it, so the list is empty.
		write_reg(REG_MIN_COUNT, 8'd255);
		add_run(6'd9, 5);
		add_pixel(6'd9, 1'b1, 1'b1);
		drain();

		// A zero threshold reports every nonzero label counted; labels above 20 are dropped.
		write_reg(REG_MIN_COUNT, 8'd0);
		write_reg(REG_LABEL_LIMIT, {2'($urandom_range(3)), 6'd20});
		add_random_frames(40);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Only label zero is counted, so every list is empty.
		write_reg(REG_MIN_COUNT, 8'd2);
		write_reg(REG_LABEL_LIMIT, 8'd0);
		add_random_frames(25);
		drain();

		write_reg(REG_MIN_COUNT, 8'($urandom_range(1, 4)));
		write_reg(REG_LABEL_LIMIT, 8'($urandom_range(30, 63)));
		add_random_frames(40);
		drain();

		if (fail_count == 0 && expected_neighbors.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[border_label_neighbor_finder.f]
rtl/blnf_pkg.sv
rtl/blnf_ctrl.sv
rtl/blnf_datapath.sv
rtl/border_label_neighbor_finder.sv
test/tb.sv
